// ===== rtl/core/scsa_pkg.sv =====
package scsa_pkg;

  // Field widths
  localparam int ADDR_W = 64;
  localparam int SIZE_W = 16;

  // Allocator geometry
  localparam int NUM_CLASSES  = 10;
  localparam int REGION_BYTES = 1024;
  localparam int OFF_W        = $clog2(REGION_BYTES);
  localparam int CLS_W        = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  // Valid marks are kept in words of WORD_BITS slots
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = $clog2(WORD_BITS);

  // Slots of class c: one per block of 2^(c+1) bytes, none if the block exceeds a region
  function automatic int class_slots(int c);
    return (c + 1 > OFF_W) ? 0 : (REGION_BYTES >> (c + 1));
  endfunction

  // First slot index of class c in the shared slot store
  function automatic int class_first(int c);
    int first;
    first = 0;
    for (int k = 0; k < c; k++) begin
      first += class_slots(k);
    end
    return first;
  endfunction

  localparam int SLOT_TOTAL = class_first(NUM_CLASSES);
  localparam int NUM_WORDS  = (SLOT_TOTAL + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int SLOT_W     = WORD_IDX_W + BIT_W;
  localparam int MEM_DEPTH  = NUM_WORDS * WORD_BITS;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_REJECT = 2'd1,
    ST_FULL   = 2'd2,
    ST_NULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_WSEL,
    S_BSEL,
    S_SUM
  } state_e;

endpackage

// ===== rtl/core/size_class_slot_allocator.sv =====
// Steps: done_o is registered from the last step of the full path (alloc: decode,
// word pick, bit pick, add; free: decode, region check, word pick, bit pick). Bad size
// and null free end at decode, a rejected free at the region check, an exhausted class
// at decode or the bit pick. Throughput: one request at a time; busy is high from accept
// until the result beat. Reset: async, active low; the slot store is then refilled one
// slot a cycle, all SLOT_TOTAL (1023) slots, busy high. Receiver cannot stall: one-cycle beat.
module size_class_slot_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        kind_i,
  input  logic [scsa_pkg::SIZE_W-1:0] request_size_i,
  input  logic [scsa_pkg::ADDR_W-1:0] free_address_i,
  input  logic                        pool_base_we_i,
  input  logic [scsa_pkg::ADDR_W-1:0] pool_base_i,
  output logic                        done_o,
  output logic [scsa_pkg::ADDR_W-1:0] granted_address_o,
  output logic [1:0]                  status_o
);
  import scsa_pkg::*;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_e                             state_q, state_d;
  logic                               kind_q;
  logic [SIZE_W-1:0]                  size_q;
  logic [ADDR_W-1:0]                  addr_q;
  logic [ADDR_W-1:0]                  base_q;
  logic [ADDR_W-1:0]                  acc_q;      // free address minus pool base
  logic [CLS_W-1:0]                   cls_q;
  logic [WORD_IDX_W-1:0]              widx_q;
  logic [SLOT_W-1:0]                  init_idx_q;
  logic [NUM_WORDS-1:0][WORD_BITS-1:0] valid_q;   // one mark per slot
  logic [OFF_W-1:0]                   mem_q [MEM_DEPTH];  // slot offsets
  logic [OFF_W-1:0]                   rdata_q;
  logic                               done_q;
  logic [ADDR_W-1:0]                  gaddr_q;
  status_e                            status_q;

  // ---------------------------------------------------------------------------
  // Lookups
  // ---------------------------------------------------------------------------
  // Allocate: size must equal one class block size exactly.
  logic             dec_hit, dec_empty;
  logic [CLS_W-1:0] dec_cls;

  always_comb begin
    dec_hit   = 1'b0;
    dec_empty = 1'b0;
    dec_cls   = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if ({1'b0, size_q} == (SIZE_W+1)'(1 << (c + 1))) begin
        dec_hit   = 1'b1;
        dec_cls   = CLS_W'(c);
        dec_empty = (class_slots(c) == 0);
      end
    end
  end

  // Free: regions are contiguous, so the upper bits of (addr - base) name the class
  // and the low bits are the region offset, checked for range and block alignment.
  logic                   chk_hit;
  logic [CLS_W-1:0]       chk_cls;
  logic [ADDR_W-OFF_W-1:0] chk_hi;
  logic [OFF_W-1:0]       chk_off;

  assign chk_hi  = acc_q[ADDR_W-1:OFF_W];
  assign chk_off = acc_q[OFF_W-1:0];

  always_comb begin
    chk_hit = 1'b0;
    chk_cls = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (class_slots(c) > 0 && chk_hi == (ADDR_W-OFF_W)'(c) &&
          chk_off <= OFF_W'(REGION_BYTES - (1 << (c + 1))) &&
          (chk_off & OFF_W'((1 << (c + 1)) - 1)) == '0) begin
        chk_hit = 1'b1;
        chk_cls = CLS_W'(c);
      end
    end
  end

  // Slot range of the current class
  logic [SLOT_W-1:0]     cls_first, cls_end, cls_last;
  logic [WORD_IDX_W-1:0] w_first, w_last;

  always_comb begin
    cls_first = '0;
    cls_end   = '0;
    cls_last  = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (cls_q == CLS_W'(c)) begin
        cls_first = SLOT_W'(class_first(c));
        cls_end   = SLOT_W'(class_first(c) + class_slots(c));
        cls_last  = SLOT_W'(class_first(c) + class_slots(c) - 1);
      end
    end
  end

  assign w_first = cls_first[SLOT_W-1:BIT_W];
  assign w_last  = cls_last[SLOT_W-1:BIT_W];

  // Word pick: first word of the class holding a valid (alloc) or empty (free) slot.
  // Words shared by several small classes are only ever the class's single word,
  // so a coarse hit there is settled by the bit pick.
  logic [WORD_IDX_W-1:0] w_pick;
  logic                  w_found;

  always_comb begin
    w_pick  = w_first;
    w_found = 1'b0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (!w_found && WORD_IDX_W'(w) >= w_first && WORD_IDX_W'(w) <= w_last &&
          (kind_q ? ~&valid_q[w] : |valid_q[w])) begin
        w_found = 1'b1;
        w_pick  = WORD_IDX_W'(w);
      end
    end
  end

  // Bit pick: lowest slot of the class in the picked word
  logic [WORD_BITS-1:0] word_sel;
  logic                 b_hit;
  logic [BIT_W-1:0]     b_pick;
  logic [SLOT_W-1:0]    slot_idx;

  assign word_sel = valid_q[widx_q];

  always_comb begin
    logic [SLOT_W-1:0] gidx;
    b_hit  = 1'b0;
    b_pick = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      gidx = {widx_q, BIT_W'(b)};
      if (gidx >= cls_first && gidx < cls_end && (kind_q ? !word_sel[b] : word_sel[b])) begin
        b_hit  = 1'b1;
        b_pick = BIT_W'(b);
      end
    end
  end

  assign slot_idx = {widx_q, b_pick};

  // Reset contents of the slot store: slot j of class c holds j * 2^(c+1)
  logic [OFF_W-1:0] init_val;

  always_comb begin
    logic [SLOT_W-1:0] rel;
    init_val = '0;
    rel      = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (class_slots(c) > 0 && init_idx_q >= SLOT_W'(class_first(c)) &&
          init_idx_q < SLOT_W'(class_first(c) + class_slots(c))) begin
        rel      = init_idx_q - SLOT_W'(class_first(c));
        init_val = OFF_W'(rel << (c + 1));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared 64-bit adder: free offset (addr - base) and grant address (base + offset)
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] add_a, add_b, add_sum;
  logic              add_ci;

  assign add_sum = add_a + add_b + ADDR_W'(add_ci);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (init_idx_q == SLOT_W'(SLOT_TOTAL - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (kind_q) begin
          state_d = (addr_q == '0) ? S_IDLE : S_CHECK;
        end else begin
          state_d = (!dec_hit || dec_empty) ? S_IDLE : S_WSEL;
        end
      end
      S_CHECK: begin
        state_d = chk_hit ? S_WSEL : S_IDLE;
      end
      S_WSEL: begin
        state_d = S_BSEL;
      end
      S_BSEL: begin
        state_d = (b_hit && !kind_q) ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control outputs of the sequencer
  // ---------------------------------------------------------------------------
  logic             fin, fin_sum, acc_we, cls_we, widx_we, vld_we;
  status_e          fin_st;
  logic [CLS_W-1:0] cls_nxt;
  logic             mem_we, mem_re;
  logic [SLOT_W-1:0] mem_waddr;
  logic [OFF_W-1:0] mem_wdata;

  always_comb begin
    fin       = 1'b0;
    fin_sum   = 1'b0;
    fin_st    = ST_DONE;
    acc_we    = 1'b0;
    cls_we    = 1'b0;
    cls_nxt   = dec_cls;
    widx_we   = 1'b0;
    vld_we    = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = slot_idx;
    mem_wdata = acc_q[OFF_W-1:0];
    add_a     = base_q;
    add_b     = ADDR_W'({cls_q, rdata_q});
    add_ci    = 1'b0;
    case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_idx_q;
        mem_wdata = init_val;
      end
      S_DECODE: begin
        if (kind_q) begin
          // null check comes before any region match
          if (addr_q == '0) begin
            fin    = 1'b1;
            fin_st = ST_NULL;
          end
          add_a  = addr_q;
          add_b  = ~base_q;
          add_ci = 1'b1;
          acc_we = 1'b1;
        end else begin
          if (!dec_hit) begin
            fin    = 1'b1;
            fin_st = ST_REJECT;
          end else if (dec_empty) begin
            fin    = 1'b1;
            fin_st = ST_FULL;
          end
          cls_we = 1'b1;
        end
      end
      S_CHECK: begin
        cls_we  = 1'b1;
        cls_nxt = chk_cls;
        if (!chk_hit) begin
          fin    = 1'b1;
          fin_st = ST_REJECT;
        end
      end
      S_WSEL: begin
        widx_we = 1'b1;
      end
      S_BSEL: begin
        if (!b_hit) begin
          fin    = 1'b1;
          fin_st = ST_FULL;
        end else begin
          vld_we = 1'b1;
          if (kind_q) begin
            mem_we = 1'b1;
            fin    = 1'b1;
            fin_st = ST_DONE;
          end else begin
            mem_re = 1'b1;
          end
        end
      end
      S_SUM: begin
        fin     = 1'b1;
        fin_sum = 1'b1;
        fin_st  = ST_DONE;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      init_idx_q <= '0;
      base_q     <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= fin;
      if (state_q == S_INIT) init_idx_q <= init_idx_q + SLOT_W'(1);
      if (pool_base_we_i) base_q <= pool_base_i;
    end
  end

  // Valid marks: every real slot starts valid, pad bits stay clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        for (int b = 0; b < WORD_BITS; b++) begin
          valid_q[w][b] <= (w * WORD_BITS + b < SLOT_TOTAL);
        end
      end
    end else if (vld_we) begin
      valid_q[widx_q][b_pick] <= kind_q;
    end
  end

  // Request beat and working payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      kind_q <= kind_i;
      size_q <= request_size_i;
      addr_q <= free_address_i;
    end
    if (acc_we) acc_q <= add_sum;
    if (cls_we) cls_q <= cls_nxt;
    if (widx_we) widx_q <= w_pick;
    if (fin) begin
      gaddr_q  <= fin_sum ? add_sum : '0;
      status_q <= fin_st;
    end
  end

  // Slot offset store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rdata_q <= mem_q[slot_idx];
  end

  // ---------------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------------
  assign busy              = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign granted_address_o = gaddr_q;
  assign status_o          = status_q;

endmodule
